// ===== rtl/flpc_pkg.sv =====
package flpc_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ON   = 2'd1,
    OP_OFF  = 2'd2,
    OP_SEND = 2'd3
  } flpc_op_e;

  typedef struct packed {
    flpc_op_e    operation;
    logic [7:0]  byte_value;
  } flpc_in_t;

  typedef struct packed {
    logic enable_pin;
    logic mode_pin;
    logic busy_res;
    logic timed_out;
  } flpc_out_t;

  localparam int PhaseW   = 10;
  localparam int CountW   = 4;
  localparam int ElapsedW = 26;
  localparam int DutyW    = 5;
  localparam int TimeoutW = 16;

  localparam logic [PhaseW-1:0] TWait    = 10'd100;
  localparam logic [PhaseW-1:0] TPulseLo = 10'd40;
  localparam logic [PhaseW-1:0] TPulseHi = 10'd80;
  localparam logic [PhaseW-1:0] TStart   = 10'd30;
  localparam logic [PhaseW-1:0] TEodLow  = 10'd20;
  localparam logic [PhaseW-1:0] TEodEnd  = 10'd1020;

  localparam logic [CountW-1:0]   BitsPerByte = 4'd8;
  localparam logic [ElapsedW-1:0] ElapsedMax  = 26'h3FF_FFFF;

  localparam logic [2:0] AddrDuty    = 3'd0;
  localparam logic [2:0] AddrTimeout = 3'd4;

endpackage

// ===== rtl/flash_led_pulse_controller.sv =====
// Channel  | Signals                                | Transaction when
// ---------+----------------------------------------+---------------------------
// in       | in_valid_i, in_stall_o, in_data_i      | in_valid_i && !in_stall_o
// out      | out_valid_o, out_stall_i, out_data_o   | out_valid_o && !out_stall_i
// config   | psel, penable, pwrite, paddr, pwdata   | psel && penable && pwrite
//
// One item per cycle while in_stall_o is low: the state update and the result are formed
// in the cycle of acceptance, and the result is registered in the output or skid register.
// A two-entry output stage (result register plus skid register) absorbs a stall;
// in_stall_o rises only once both entries hold results.
// Reset clears the pins, the sequence, the timeout and the registers (duty -1).
module flash_led_pulse_controller #(
  parameter int TICKS_PER_MS   = 1000,
  parameter int MAX_PULSE_DUTY = 11
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  flpc_pkg::flpc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output flpc_pkg::flpc_out_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import flpc_pkg::*;

  localparam int TickW = $clog2(TICKS_PER_MS + 1);
  localparam int ProdW = (TimeoutW + TickW > ElapsedW) ? TimeoutW + TickW : ElapsedW;
  localparam logic [TickW-1:0]       TicksMs = TickW'(TICKS_PER_MS);
  localparam logic signed [DutyW-1:0] MaxDuty = DutyW'(MAX_PULSE_DUTY);

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT, PH_PLOW, PH_PHIGH, PH_START, PH_BLOW, PH_BHIGH, PH_EOD
  } phase_e;

  logic signed [DutyW-1:0] duty_q;
  logic [TimeoutW-1:0]     timeout_ms_q;
  logic [ElapsedW-1:0]     limit_q, limit_d;
  logic [ElapsedW-1:0]     target_q, target_d;
  logic [ElapsedW-1:0]     elapsed_q, elapsed_d, elapsed_inc;
  logic                    run_q, run_d;
  phase_e                  phase_q, phase_d;
  logic [PhaseW-1:0]       pm_q, pm_d, pm_inc;
  logic [CountW-1:0]       cnt_q, cnt_d, cnt_dec;
  logic [7:0]              shift_q, shift_d;
  logic                    en_q, en_d;
  logic                    mode_q, mode_d;
  logic                    fired;
  logic [ProdW-1:0]        prod;
  logic                    cfg_wr;
  logic                    in_acc;
  logic                    out_take;
  flpc_out_t               res;
  flpc_out_t               out_q, skid_q;
  logic                    out_valid_q, skid_valid_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {16'd0, timeout_ms_q} : {{(32-DutyW){duty_q[DutyW-1]}}, duty_q};

  assign prod = ProdW'(pwdata[TimeoutW-1:0]) * ProdW'(TicksMs);
  assign limit_d = (prod > ProdW'(ElapsedMax)) ? ElapsedMax : prod[ElapsedW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q       <= '1;
      timeout_ms_q <= '0;
      limit_q      <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == AddrTimeout[2]) begin
        timeout_ms_q <= pwdata[TimeoutW-1:0];
        limit_q      <= limit_d;
      end else begin
        duty_q <= pwdata[DutyW-1:0];
      end
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  assign pm_inc      = pm_q + 1'b1;
  assign cnt_dec     = cnt_q - 1'b1;
  assign elapsed_inc = (elapsed_q < ElapsedMax) ? elapsed_q + 1'b1 : elapsed_q;

  always_comb begin
    phase_d   = phase_q;
    pm_d      = pm_q;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    en_d      = en_q;
    mode_d    = mode_q;
    run_d     = run_q;
    elapsed_d = elapsed_q;
    target_d  = target_q;
    fired     = 1'b0;
    if (in_acc) begin
      case (in_data_i.operation)
        OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            pm_d = pm_inc;
            case (phase_q)
              PH_WAIT: begin
                if (pm_inc >= TWait) begin
                  pm_d = '0;
                  if (cnt_q == '0) begin
                    phase_d = PH_IDLE;
                    en_d    = 1'b1;
                  end else begin
                    phase_d = PH_PLOW;
                    en_d    = 1'b0;
                  end
                end
              end
              PH_PLOW: begin
                if (pm_inc >= TPulseLo) begin
                  phase_d = PH_PHIGH;
                  pm_d    = '0;
                  en_d    = 1'b1;
                end
              end
              PH_PHIGH: begin
                if (pm_inc >= TPulseHi) begin
                  cnt_d = cnt_dec;
                  pm_d  = '0;
                  if (cnt_dec == '0) begin
                    phase_d = PH_IDLE;
                    en_d    = 1'b1;
                  end else begin
                    phase_d = PH_PLOW;
                    en_d    = 1'b0;
                  end
                end
              end
              PH_START: begin
                if (pm_inc >= TStart) begin
                  phase_d = PH_BLOW;
                  pm_d    = '0;
                  en_d    = 1'b0;
                end
              end
              PH_BLOW: begin
                if (pm_inc >= (shift_q[7] ? TPulseLo : TPulseHi)) begin
                  phase_d = PH_BHIGH;
                  pm_d    = '0;
                  en_d    = 1'b1;
                end
              end
              PH_BHIGH: begin
                if (pm_inc >= (shift_q[7] ? TPulseHi : TPulseLo)) begin
                  shift_d = {shift_q[6:0], 1'b0};
                  cnt_d   = cnt_dec;
                  pm_d    = '0;
                  en_d    = 1'b0;
                  phase_d = (cnt_dec == '0) ? PH_EOD : PH_BLOW;
                end
              end
              PH_EOD: begin
                if (pm_inc >= TEodEnd) begin
                  phase_d = PH_IDLE;
                  pm_d    = '0;
                  en_d    = 1'b1;
                end else if (pm_inc >= TEodLow) begin
                  en_d = 1'b1;
                end
              end
              default: begin
                phase_d = PH_IDLE;
                pm_d    = '0;
              end
            endcase
          end
          if (run_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= target_q) begin
              en_d      = 1'b0;
              mode_d    = 1'b0;
              phase_d   = PH_IDLE;
              pm_d      = '0;
              cnt_d     = '0;
              run_d     = 1'b0;
              elapsed_d = '0;
              fired     = 1'b1;
            end
          end
        end
        OP_ON: begin
          if (phase_q == PH_IDLE) begin
            if (timeout_ms_q != '0) begin
              target_d  = limit_q;
              run_d     = 1'b1;
              elapsed_d = '0;
            end
            if (duty_q <= MaxDuty) begin
              mode_d  = 1'b0;
              cnt_d   = (duty_q > 0) ? duty_q[CountW-1:0] : '0;
              phase_d = PH_WAIT;
              pm_d    = '0;
              en_d    = 1'b1;
            end else begin
              mode_d = 1'b1;
            end
          end
        end
        OP_OFF: begin
          if (phase_q == PH_IDLE) begin
            en_d      = 1'b0;
            mode_d    = 1'b0;
            phase_d   = PH_IDLE;
            pm_d      = '0;
            cnt_d     = '0;
            run_d     = 1'b0;
            elapsed_d = '0;
          end
        end
        OP_SEND: begin
          if (phase_q == PH_IDLE) begin
            shift_d = in_data_i.byte_value;
            cnt_d   = BitsPerByte;
            phase_d = PH_START;
            pm_d    = '0;
            en_d    = 1'b1;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
    res.enable_pin = en_d;
    res.mode_pin   = mode_d;
    res.busy_res   = (phase_d != PH_IDLE);
    res.timed_out  = fired;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pm_q      <= '0;
      cnt_q     <= '0;
      shift_q   <= '0;
      en_q      <= 1'b0;
      mode_q    <= 1'b0;
      run_q     <= 1'b0;
      elapsed_q <= '0;
      target_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      pm_q      <= pm_d;
      cnt_q     <= cnt_d;
      shift_q   <= shift_d;
      en_q      <= en_d;
      mode_q    <= mode_d;
      run_q     <= run_d;
      elapsed_q <= elapsed_d;
      target_q  <= target_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= in_acc;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (in_acc) begin
          skid_q <= res;
        end
      end else if (in_acc) begin
        out_q <= res;
      end
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in the output register");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i && in_acc))
    else $error("skid entry filled without a stalled output");

  a_idle_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (cnt_q == '0))
    else $error("pulse or bit count left over in idle");

  a_stopped_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |-> (elapsed_q == '0))
    else $error("elapsed time kept while the timeout is stopped");

  a_fire_drops_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fired) |=> (!en_q && !mode_q && phase_q == PH_IDLE && !run_q))
    else $error("timeout fired without switching the lamp off");

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import flpc_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_ITEMS     = 1250;
  localparam int RANDOM_PHASES    = 8;
  localparam int DUTY_FLASH_ABOVE = 11;
  localparam int US_PER_MS        = 1000;

  localparam logic [9:0]  US_WAIT     = 10'd100;
  localparam logic [9:0]  US_SHORT    = 10'd40;
  localparam logic [9:0]  US_LONG     = 10'd80;
  localparam logic [9:0]  US_START    = 10'd30;
  localparam logic [9:0]  US_EOD_LOW  = 10'd20;
  localparam logic [9:0]  US_EOD_END  = 10'd1020;
  localparam logic [3:0]  BYTE_BITS   = 4'd8;
  localparam logic [25:0] ELAPSED_CAP = 26'h3FF_FFFF;

  typedef enum logic [2:0] {
    LAMP_IDLE,
    LAMP_WAIT,
    LAMP_PULSE_LO,
    LAMP_PULSE_HI,
    LAMP_START,
    LAMP_BIT_LO,
    LAMP_BIT_HI,
    LAMP_EOD
  } lamp_phase_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  flpc_in_t    in_data_i   = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  flpc_out_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  logic calm = 1'b0;
  int   mismatch_count = 0;
  int   result_count   = 0;
  int   item_count     = 0;
  int   expiry_count   = 0;
  int   transfer_count = 0;
  int   cycle_count    = 0;

  flpc_out_t pin_levels_q[$];

  logic signed [4:0] duty_setting    = -5'sd1;
  logic [15:0]       timeout_setting = '0;

  logic        lamp_en     = 1'b0;
  logic        lamp_mode   = 1'b0;
  lamp_phase_e lamp_phase  = LAMP_IDLE;
  logic [9:0]  lamp_us     = '0;
  logic [3:0]  lamp_left   = '0;
  logic [7:0]  lamp_shift  = '0;
  logic        tmo_running = 1'b0;
  logic [25:0] tmo_elapsed = '0;
  logic [25:0] tmo_target  = '0;

  flash_led_pulse_controller i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 9);
  end

  task automatic enter_phase(input lamp_phase_e ph, input logic level);
    lamp_phase = ph;
    lamp_us    = '0;
    lamp_en    = level;
  endtask

  task automatic lamp_off();
    lamp_en    = 1'b0;
    lamp_mode  = 1'b0;
    lamp_phase = LAMP_IDLE;
    lamp_us    = '0;
    lamp_left  = '0;
  endtask

  task automatic predict_pins(input flpc_in_t item);
    logic        was_busy;
    logic        fired;
    logic        msb;
    logic [31:0] target_wide;
    was_busy = (lamp_phase != LAMP_IDLE);
    fired    = 1'b0;
    msb      = lamp_shift[7];
    if (item.operation == OP_TICK) begin
      if (lamp_phase != LAMP_IDLE) begin
        lamp_us = lamp_us + 10'd1;
        case (lamp_phase)
          LAMP_WAIT: begin
            if (lamp_us >= US_WAIT) begin
              if (lamp_left == 0) enter_phase(LAMP_IDLE, 1'b1);
              else enter_phase(LAMP_PULSE_LO, 1'b0);
            end
          end
          LAMP_PULSE_LO: begin
            if (lamp_us >= US_SHORT) enter_phase(LAMP_PULSE_HI, 1'b1);
          end
          LAMP_PULSE_HI: begin
            if (lamp_us >= US_LONG) begin
              lamp_left = lamp_left - 4'd1;
              if (lamp_left == 0) enter_phase(LAMP_IDLE, 1'b1);
              else enter_phase(LAMP_PULSE_LO, 1'b0);
            end
          end
          LAMP_START: begin
            if (lamp_us >= US_START) enter_phase(LAMP_BIT_LO, 1'b0);
          end
          LAMP_BIT_LO: begin
            if (lamp_us >= (msb ? US_SHORT : US_LONG)) enter_phase(LAMP_BIT_HI, 1'b1);
          end
          LAMP_BIT_HI: begin
            if (lamp_us >= (msb ? US_LONG : US_SHORT)) begin
              lamp_shift = lamp_shift << 1;
              lamp_left  = lamp_left - 4'd1;
              if (lamp_left == 0) enter_phase(LAMP_EOD, 1'b0);
              else enter_phase(LAMP_BIT_LO, 1'b0);
            end
          end
          LAMP_EOD: begin
            if (lamp_us >= US_EOD_END) enter_phase(LAMP_IDLE, 1'b1);
            else if (lamp_us >= US_EOD_LOW) lamp_en = 1'b1;
          end
          default: enter_phase(LAMP_IDLE, lamp_en);
        endcase
      end
      if (tmo_running) begin
        if (tmo_elapsed < ELAPSED_CAP) tmo_elapsed = tmo_elapsed + 26'd1;
        if (tmo_elapsed >= tmo_target) begin
          lamp_off();
          tmo_running = 1'b0;
          tmo_elapsed = '0;
          fired       = 1'b1;
        end
      end
    end else if (!was_busy) begin
      case (item.operation)
        OP_ON: begin
          if (timeout_setting != 0) begin
            target_wide = 32'(timeout_setting) * US_PER_MS;
            tmo_target  = (target_wide > 32'(ELAPSED_CAP)) ? ELAPSED_CAP : target_wide[25:0];
            tmo_running = 1'b1;
            tmo_elapsed = '0;
          end
          if (duty_setting <= DUTY_FLASH_ABOVE) begin
            lamp_mode = 1'b0;
            lamp_left = (duty_setting > 0) ? duty_setting[3:0] : 4'd0;
            enter_phase(LAMP_WAIT, 1'b1);
          end else begin
            lamp_mode = 1'b1;
          end
        end
        OP_OFF: begin
          lamp_off();
          tmo_running = 1'b0;
          tmo_elapsed = '0;
        end
        default: begin
          lamp_shift = item.byte_value;
          lamp_left  = BYTE_BITS;
          enter_phase(LAMP_START, 1'b1);
          transfer_count++;
        end
      endcase
    end
    if (fired) expiry_count++;
    pin_levels_q.push_back('{enable_pin: lamp_en, mode_pin: lamp_mode,
                             busy_res: (lamp_phase != LAMP_IDLE), timed_out: fired});
  endtask

  task automatic check_pins(input flpc_out_t got);
    flpc_out_t want;
    result_count++;
    if (pin_levels_q.size() == 0) begin
      $error("unexpected result %p", got);
      mismatch_count++;
    end else begin
      want = pin_levels_q.pop_front();
      if (got.enable_pin !== want.enable_pin) begin
        $error("enable_pin expected %0b actual %0b", want.enable_pin, got.enable_pin);
        mismatch_count++;
      end
      if (got.mode_pin !== want.mode_pin) begin
        $error("mode_pin expected %0b actual %0b", want.mode_pin, got.mode_pin);
        mismatch_count++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res expected %0b actual %0b", want.busy_res, got.busy_res);
        mismatch_count++;
      end
      if (got.timed_out !== want.timed_out) begin
        $error("timed_out expected %0b actual %0b", want.timed_out, got.timed_out);
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_pins(out_data_o);
  end

  task automatic send_item(input flpc_op_e op, input logic [7:0] value);
    flpc_in_t item;
    item.operation  = op;
    item.byte_value = value;
    while (!calm && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_pins(item);
    item_count++;
  endtask

  task automatic run_ticks(input int count);
    repeat (count) send_item(OP_TICK, 8'($urandom));
  endtask

  task automatic ticks_until_idle();
    while (lamp_phase != LAMP_IDLE) send_item(OP_TICK, 8'($urandom));
  endtask

  task automatic ticks_until_expiry();
    while (tmo_running) send_item(OP_TICK, 8'($urandom));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pin_levels_q.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_lamp_config(input int duty, input int timeout_ms);
    drain_results();
    write_reg(AddrDuty, 32'(duty) & 32'h1F);
    write_reg(AddrTimeout, 32'(timeout_ms) & 32'hFFFF);
    duty_setting    = 5'(duty);
    timeout_setting = 16'(timeout_ms);
  endtask

  task automatic test_movie_mode();
    // reset duty is negative: wait, then no pulses
    send_item(OP_ON, 8'h00);
    ticks_until_idle();
    set_lamp_config(0, 0);
    send_item(OP_ON, 8'hFF);
    ticks_until_idle();
    set_lamp_config(2, 0);
    send_item(OP_ON, 8'h5A);
    run_ticks(10);
    send_item(OP_OFF, 8'hA5);
    send_item(OP_SEND, 8'hFF);
    send_item(OP_ON, 8'h00);
    ticks_until_idle();
    send_item(OP_OFF, 8'h00);
  endtask

  task automatic test_flash_mode();
    set_lamp_config(1, 0);
    send_item(OP_ON, 8'h00);
    ticks_until_idle();
    set_lamp_config(12, 0);
    send_item(OP_ON, 8'hFF);
    run_ticks(5);
    send_item(OP_OFF, 8'h00);
    set_lamp_config(15, 0);
    send_item(OP_ON, 8'h0F);
    send_item(OP_ON, 8'hF0);
    send_item(OP_OFF, 8'h00);
    send_item(OP_OFF, 8'hFF);
  endtask

  task automatic test_byte_send();
    set_lamp_config(12, 0);
    send_item(OP_ON, 8'h00);
    send_item(OP_SEND, 8'hA5);
    run_ticks(50);
    send_item(OP_OFF, 8'h00);
    send_item(OP_SEND, 8'hFF);
    ticks_until_idle();
    send_item(OP_OFF, 8'h00);
  endtask

  task automatic test_timeout();
    set_lamp_config(12, 1);
    send_item(OP_ON, 8'h00);
    run_ticks(600);
    set_lamp_config(12, 0);
    send_item(OP_ON, 8'h00);
    ticks_until_expiry();
    set_lamp_config(12, 1);
    send_item(OP_ON, 8'h00);
    run_ticks(600);
    send_item(OP_ON, 8'h00);
    run_ticks(300);
    send_item(OP_OFF, 8'h00);
    run_ticks(800);
    // abort a byte transfer on expiry
    send_item(OP_ON, 8'h00);
    send_item(OP_SEND, 8'h00);
    ticks_until_expiry();
    set_lamp_config(-1, 65535);
    send_item(OP_ON, 8'h00);
    run_ticks(20);
    send_item(OP_OFF, 8'h00);
  endtask

  task automatic test_random_traffic();
    int duty;
    int tmo;
    int budget;
    int roll;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin duty = -1; tmo = 0; end
        1: begin duty = 0;  tmo = 1; end
        2: begin duty = 1;  tmo = 2; end
        3: begin duty = 11; tmo = 65535; end
        4: begin duty = 12; tmo = 0; end
        5: begin duty = 15; tmo = 1; end
        6: begin
          duty = int'($urandom_range(0, 16)) - 1;
          tmo  = int'($urandom_range(0, 3));
        end
        default: begin
          duty = int'($urandom_range(0, 16)) - 1;
          tmo  = int'($urandom_range(0, 65535));
        end
      endcase
      set_lamp_config(duty, tmo);
      calm   = (p == 5);
      budget = item_count + RANDOM_ITEMS / RANDOM_PHASES;
      while (item_count < budget) begin
        roll = int'($urandom_range(0, 99));
        if (lamp_phase != LAMP_IDLE) begin
          if (roll < 8) send_item(flpc_op_e'(2'($urandom_range(1, 3))), 8'($urandom));
          else run_ticks(int'($urandom_range(1, 120)));
        end else if (roll < 35) begin
          send_item(OP_ON, 8'($urandom));
        end else if (roll < 43) begin
          send_item(OP_SEND, 8'($urandom));
        end else if (roll < 55) begin
          send_item(OP_OFF, 8'($urandom));
        end else if (roll < 65) begin
          send_item(flpc_op_e'(2'($urandom_range(0, 3))), 8'($urandom));
        end else if (roll < 67) begin
          drain_results();
        end else begin
          run_ticks(int'($urandom_range(1, 60)));
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_movie_mode();
    test_flash_mode();
    test_byte_send();
    test_timeout();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d items and %0d checked results, with %0d byte transfers",
             item_count, result_count, transfer_count);
    $display("and %0d timeout expiries across movie, flash and serial modes.", expiry_count);
    if (mismatch_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
